[rtl/hvn_pkg.sv]
// Package for the height-map vertex and normal unit.
// Holds the register block types and constants; no dependencies.
package hvn_pkg;

  localparam int PaddrW = 4;

  localparam logic [1:0] RegHeightStep = 2'd0;
  localparam logic [1:0] RegUStep      = 2'd1;
  localparam logic [1:0] RegVStep      = 2'd2;

  localparam logic [23:0] HeightStepRst = 24'd47514;
  localparam logic [23:0] UStepRst      = 24'd65536;
  localparam logic [23:0] VStepRst      = 24'd65536;

  localparam logic [24:0] TexOne = 25'h1000000;

  typedef struct packed {
    logic [23:0] height_step;
    logic [23:0] u_step;
    logic [23:0] v_step;
  } cfg_t;

endpackage

[rtl/hvn_cfg.sv]
// Configuration register block for the height-map vertex and normal unit.
// APB-style write/read port; depends on hvn_pkg.
module hvn_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hvn_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output hvn_pkg::cfg_t              cfg_o
);
  import hvn_pkg::*;

  logic [23:0] height_step_q;
  logic [23:0] u_step_q;
  logic [23:0] v_step_q;
  logic [1:0]  idx;
  logic        wr;

  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_step_q <= HeightStepRst;
      u_step_q      <= UStepRst;
      v_step_q      <= VStepRst;
    end else if (wr) begin
      unique case (idx)
        RegHeightStep: height_step_q <= pwdata[23:0];
        RegUStep:      u_step_q      <= pwdata[23:0];
        RegVStep:      v_step_q      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegHeightStep: prdata = 32'(height_step_q);
      RegUStep:      prdata = 32'(u_step_q);
      RegVStep:      prdata = 32'(v_step_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.height_step = height_step_q;
  assign cfg_o.u_step      = u_step_q;
  assign cfg_o.v_step      = v_step_q;

endmodule

[rtl/hvn_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage, with a sideband word.
// No package dependencies.
module hvn_sqrt_pipe #(
  parameter int W  = 62,
  parameter int SW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [W-1:0]   rad_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [W/2-1:0] root_o,
  output logic [SW-1:0]  side_o
);
  localparam int N = W / 2;

  logic          vld_q  [N];
  logic [W-1:0]  rem_q  [N];
  logic [W-1:0]  res_q  [N];
  logic [SW-1:0] side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0]  v_in;
    logic [W-1:0]  r_in;
    logic [SW-1:0] s_in;
    logic          vl_in;
    logic [W-1:0]  bit_c;
    logic [W-1:0]  t;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in  = rad_i;
      assign r_in  = '0;
      assign s_in  = side_i;
      assign vl_in = valid_i;
    end else begin : g_next
      assign v_in  = rem_q[k-1];
      assign r_in  = res_q[k-1];
      assign s_in  = side_q[k-1];
      assign vl_in = vld_q[k-1];
    end

    assign bit_c = W'(1) << (W - 2 - 2 * k);
    assign t     = r_in + bit_c;
    assign ge    = v_in >= t;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? v_in - t : v_in;
        res_q[k]  <= ge ? (r_in >> 1) + bit_c : r_in >> 1;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = res_q[N-1][N-1:0];
  assign side_o  = side_q[N-1];

endmodule

[rtl/hvn_div_pipe.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage, with a sideband word.
// Expects the quotient to fit in QW bits. No package dependencies.
module hvn_div_pipe #(
  parameter int NW = 60,
  parameter int DW = 31,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  localparam int TW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_q  [QW];
  logic [TW-1:0] rem_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [TW-1:0] r_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic          vl_in;
    logic [TW-1:0] dsh;
    logic [QW-1:0] qbit;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in  = TW'(num_i);
      assign q_in  = '0;
      assign d_in  = den_i;
      assign s_in  = side_i;
      assign vl_in = valid_i;
    end else begin : g_next
      assign r_in  = rem_q[k-1];
      assign q_in  = quo_q[k-1];
      assign d_in  = den_q[k-1];
      assign s_in  = side_q[k-1];
      assign vl_in = vld_q[k-1];
    end

    assign dsh  = TW'(d_in) << (QW - 1 - k);
    assign qbit = QW'(1) << (QW - 1 - k);
    assign ge   = r_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? r_in - dsh : r_in;
        quo_q[k]  <= ge ? (q_in | qbit) : q_in;
        den_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

[rtl/heightmap_vertex_normal_unit.sv]
// Height-map vertex and normal unit, top level.
// Depends on hvn_pkg, hvn_cfg, hvn_sqrt_pipe and hvn_div_pipe.
//
// Usage: one stencil word enters on the s_axis channel (column, row and five heights)
// and one result word leaves on the m_axis channel (scaled height, unit normal in
// Q1.15, texture coordinates in Q1.24). Height, u and v steps sit in three APB
// registers at byte addresses 0, 4 and 8; write them while the unit is empty.
// Throughput: one word per cycle while the output is not stalled. Pipeline: 179 register
// stages: three square-root pipelines (29, 31 and 31 stages, one root bit each), three
// divider pipelines (31, 31 and 16 stages, one quotient bit each) and ten arithmetic
// stages.
// Stall: the whole pipeline holds while the output word waits and m_axis_tready is
// low; s_axis_tready follows, so nothing is dropped or repeated. Bubbles travel as
// cleared valid bits.
// Reset: all valid bits clear at once and the registers return to their defaults;
// the unit accepts words in the first cycle after reset.
module heightmap_vertex_normal_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // col[11:0], row[23:12], h_centre[31:24], h_right[39:32], h_forward[47:40],
  // h_left[55:48], h_back[63:56]
  input  logic [63:0]                s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // vertex_z[31:0], normal_x[47:32], normal_y[63:48], normal_z[79:64],
  // tex_u[104:80], tex_v[129:105], zero[135:130]
  output logic [135:0]               m_axis_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hvn_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import hvn_pkg::*;

  typedef struct packed {
    logic [31:0] vertex_z;
    logic [24:0] tex_u;
    logic [24:0] tex_v;
  } glob_t;

  typedef struct packed {
    glob_t       glob;
    logic        es;
    logic [27:0] em;
  } sq1_side_t;

  typedef struct packed {
    glob_t glob;
    logic  es;
  } dv1_side_t;

  typedef struct packed {
    glob_t            glob;
    logic [5:0]       neg;
    logic [5:0][30:0] m;
  } sq2_side_t;

  typedef struct packed {
    glob_t            glob;
    logic [2:0]       neg;
    logic [2:0][30:0] m;
  } sq3_side_t;

  typedef struct packed {
    glob_t      glob;
    logic [2:0] neg;
  } dv3_side_t;

  cfg_t cfg;
  logic adv;

  hvn_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  logic out_vld_q;

  assign adv           = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = adv;

  // stage 1: height differences times step, scaled centre height, texture products
  logic [11:0]       in_col;
  logic [11:0]       in_row;
  logic [7:0]        in_hc;
  logic [7:0]        in_hn [4];
  logic signed [8:0] dif   [4];

  assign in_col   = s_axis_tdata[11:0];
  assign in_row   = s_axis_tdata[23:12];
  assign in_hc    = s_axis_tdata[31:24];
  assign in_hn[0] = s_axis_tdata[39:32];
  assign in_hn[1] = s_axis_tdata[47:40];
  assign in_hn[2] = s_axis_tdata[55:48];
  assign in_hn[3] = s_axis_tdata[63:56];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dif[i] = $signed({1'b0, in_hn[i]}) - $signed({1'b0, in_hc});
    end
  end

  logic               s1_vld_q;
  logic signed [33:0] s1_p_q [4];
  logic [31:0]        s1_vz_q;
  logic [35:0]        s1_tu_q;
  logic [35:0]        s1_tv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s1_p_q[i] <= 34'(dif[i]) * 34'($signed({1'b0, cfg.height_step}));
      end
      s1_vz_q <= 32'(in_hc) * 32'(cfg.height_step);
      s1_tu_q <= 36'(in_col) * 36'(cfg.u_step);
      s1_tv_q <= 36'(in_row) * 36'(cfg.v_step);
    end
  end

  // stage 2: edge slope magnitude and squared length, clamped texture coordinates
  logic        s2_vld_q;
  logic [57:0] s2_sq_q [4];
  logic        s2_es_q [4];
  logic [27:0] s2_em_q [4];
  glob_t       s2_glob_q;
  logic [33:0] pa      [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pa[i] = s1_p_q[i][33] ? 34'(-s1_p_q[i]) : 34'(s1_p_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s2_es_q[i] <= s1_p_q[i][33];
        s2_em_q[i] <= pa[i][31:4];
        s2_sq_q[i] <= 58'(pa[i][31:4]) * 58'(pa[i][31:4]) + (58'(1) << 40);
      end
      s2_glob_q.vertex_z <= s1_vz_q;
      s2_glob_q.tex_u    <= (s1_tu_q > 36'(TexOne)) ? TexOne : s1_tu_q[24:0];
      s2_glob_q.tex_v    <= (s1_tv_q > 36'(TexOne)) ? TexOne : s1_tv_q[24:0];
    end
  end

  // edge lengths
  sq1_side_t   sq1_side [4];
  sq1_side_t   r1_side  [4];
  logic [28:0] r1_len   [4];
  logic        r1_vld;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq1_side[i].glob = s2_glob_q;
      sq1_side[i].es   = s2_es_q[i];
      sq1_side[i].em   = s2_em_q[i];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_sqrt1
    if (l == 0) begin : g_lead
      hvn_sqrt_pipe #(.W(58), .SW($bits(sq1_side_t))) u_sqrt (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(s2_vld_q), .rad_i(s2_sq_q[l]),
        .side_i(sq1_side[l]), .valid_o(r1_vld), .root_o(r1_len[l]), .side_o(r1_side[l])
      );
    end else begin : g_lane
      hvn_sqrt_pipe #(.W(58), .SW($bits(sq1_side_t))) u_sqrt (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(s2_vld_q), .rad_i(s2_sq_q[l]),
        .side_i(sq1_side[l]), .valid_o(), .root_o(r1_len[l]), .side_o(r1_side[l])
      );
    end
  end

  // unit edges: slope part and run part
  dv1_side_t   dv1_side [4];
  dv1_side_t   d1_side  [4];
  logic [30:0] d1_am    [4];
  logic [30:0] d1_cm    [4];
  logic        d1_vld;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dv1_side[i].glob = r1_side[i].glob;
      dv1_side[i].es   = r1_side[i].es;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_div1
    if (l == 0) begin : g_lead
      hvn_div_pipe #(.NW(60), .DW(29), .QW(31), .SW($bits(dv1_side_t))) u_div_a (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(r1_vld),
        .num_i({2'b0, r1_side[l].em, 30'b0}), .den_i(r1_len[l]), .side_i(dv1_side[l]),
        .valid_o(d1_vld), .quo_o(d1_am[l]), .side_o(d1_side[l])
      );
    end else begin : g_lane
      hvn_div_pipe #(.NW(60), .DW(29), .QW(31), .SW($bits(dv1_side_t))) u_div_a (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(r1_vld),
        .num_i({2'b0, r1_side[l].em, 30'b0}), .den_i(r1_len[l]), .side_i(dv1_side[l]),
        .valid_o(), .quo_o(d1_am[l]), .side_o(d1_side[l])
      );
    end
    hvn_div_pipe #(.NW(60), .DW(29), .QW(31), .SW(1)) u_div_c (
      .clk_i, .rst_ni, .en_i(adv), .valid_i(r1_vld),
      .num_i(60'(1) << 50), .den_i(r1_len[l]), .side_i(r1_side[l].es),
      .valid_o(), .quo_o(d1_cm[l]), .side_o()
    );
  end

  // cross products, as magnitude and sign
  logic        p1_vld_q;
  logic [61:0] p1_m_q [6];
  logic [5:0]  p1_neg_q;
  glob_t       p1_glob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_m_q[0] <= 62'(d1_am[0]) * 62'(d1_cm[1]);
      p1_m_q[1] <= 62'(d1_cm[0]) * 62'(d1_am[1]);
      p1_m_q[2] <= 62'(d1_cm[0]) * 62'(d1_cm[1]);
      p1_m_q[3] <= 62'(d1_am[2]) * 62'(d1_cm[3]);
      p1_m_q[4] <= 62'(d1_cm[2]) * 62'(d1_am[3]);
      p1_m_q[5] <= 62'(d1_cm[2]) * 62'(d1_cm[3]);
      p1_neg_q  <= {1'b0, d1_side[3].es, d1_side[2].es,
                    1'b0, ~d1_side[1].es, ~d1_side[0].es};
      p1_glob_q <= d1_side[0].glob;
    end
  end

  // rescale and square the right/forward normal
  logic             p2_vld_q;
  logic [5:0][30:0] p2_m_q;
  logic [61:0]      p2_sq_q [3];
  logic [5:0]       p2_neg_q;
  glob_t            p2_glob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (adv) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        p2_m_q[i] <= p1_m_q[i][60:30];
      end
      for (int i = 0; i < 3; i++) begin
        p2_sq_q[i] <= 62'(p1_m_q[i][60:30]) * 62'(p1_m_q[i][60:30]);
      end
      p2_neg_q  <= p1_neg_q;
      p2_glob_q <= p1_glob_q;
    end
  end

  logic      p3_vld_q;
  logic [61:0] p3_sum_q;
  sq2_side_t p3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else if (adv) begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_sum_q       <= p2_sq_q[0] + p2_sq_q[1] + p2_sq_q[2];
      p3_side_q.glob <= p2_glob_q;
      p3_side_q.neg  <= p2_neg_q;
      p3_side_q.m    <= p2_m_q;
    end
  end

  logic        r2_vld;
  logic [30:0] r2_len;
  sq2_side_t   r2_side;

  hvn_sqrt_pipe #(.W(62), .SW($bits(sq2_side_t))) u_sqrt2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p3_vld_q), .rad_i(p3_sum_q),
    .side_i(p3_side_q), .valid_o(r2_vld), .root_o(r2_len), .side_o(r2_side)
  );

  // normalise the right/forward normal
  logic        d2_vld;
  logic [30:0] d2_q [3];
  sq2_side_t   d2_side;

  for (genvar l = 0; l < 3; l++) begin : g_div2
    if (l == 0) begin : g_lead
      hvn_div_pipe #(.NW(61), .DW(31), .QW(31), .SW($bits(sq2_side_t))) u_div (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(r2_vld),
        .num_i({r2_side.m[l], 30'b0}), .den_i(r2_len), .side_i(r2_side),
        .valid_o(d2_vld), .quo_o(d2_q[l]), .side_o(d2_side)
      );
    end else begin : g_lane
      hvn_div_pipe #(.NW(61), .DW(31), .QW(31), .SW($bits(sq2_side_t))) u_div (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(r2_vld),
        .num_i({r2_side.m[l], 30'b0}), .den_i(r2_len), .side_i(r2_side),
        .valid_o(), .quo_o(d2_q[l]), .side_o()
      );
    end
  end

  // sum of both normals, halved toward zero
  logic [30:0] q1_m_d [3];
  logic [2:0]  q1_neg_d;

  always_comb begin
    logic signed [32:0] a1;
    logic signed [32:0] a2;
    logic signed [32:0] sm;
    logic [32:0]        am;
    for (int i = 0; i < 3; i++) begin
      a1 = $signed(33'(d2_q[i]));
      a2 = $signed(33'(d2_side.m[i+3]));
      if (d2_side.neg[i]) begin
        a1 = -a1;
      end
      if (d2_side.neg[i+3]) begin
        a2 = -a2;
      end
      sm          = a1 + a2;
      am          = sm[32] ? 33'(-sm) : 33'(sm);
      q1_m_d[i]   = am[31:1];
      q1_neg_d[i] = sm[32];
    end
  end

  logic             q1_vld_q;
  logic [2:0][30:0] q1_m_q;
  logic [2:0]       q1_neg_q;
  glob_t            q1_glob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_vld_q <= 1'b0;
    end else if (adv) begin
      q1_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q1_m_q[i] <= q1_m_d[i];
      end
      q1_neg_q  <= q1_neg_d;
      q1_glob_q <= d2_side.glob;
    end
  end

  logic             q2_vld_q;
  logic [61:0]      q2_sq_q [3];
  logic [2:0][30:0] q2_m_q;
  logic [2:0]       q2_neg_q;
  glob_t            q2_glob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q2_vld_q <= 1'b0;
    end else if (adv) begin
      q2_vld_q <= q1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q2_sq_q[i] <= 62'(q1_m_q[i]) * 62'(q1_m_q[i]);
      end
      q2_m_q    <= q1_m_q;
      q2_neg_q  <= q1_neg_q;
      q2_glob_q <= q1_glob_q;
    end
  end

  logic        q3_vld_q;
  logic [61:0] q3_sum_q;
  sq3_side_t   q3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q3_vld_q <= 1'b0;
    end else if (adv) begin
      q3_vld_q <= q2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q3_sum_q       <= q2_sq_q[0] + q2_sq_q[1] + q2_sq_q[2];
      q3_side_q.glob <= q2_glob_q;
      q3_side_q.neg  <= q2_neg_q;
      q3_side_q.m    <= q2_m_q;
    end
  end

  logic        r3_vld;
  logic [30:0] r3_len;
  sq3_side_t   r3_side;

  hvn_sqrt_pipe #(.W(62), .SW($bits(sq3_side_t))) u_sqrt3 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(q3_vld_q), .rad_i(q3_sum_q),
    .side_i(q3_side_q), .valid_o(r3_vld), .root_o(r3_len), .side_o(r3_side)
  );

  // rounded Q1.15 numerators
  logic        rn_vld_q;
  logic [46:0] rn_num_q [3];
  logic [30:0] rn_len_q;
  dv3_side_t   rn_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rn_vld_q <= 1'b0;
    end else if (adv) begin
      rn_vld_q <= r3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rn_num_q[i] <= 47'({r3_side.m[i], 15'b0}) + 47'(r3_len >> 1);
      end
      rn_len_q       <= r3_len;
      rn_side_q.glob <= r3_side.glob;
      rn_side_q.neg  <= r3_side.neg;
    end
  end

  logic        d3_vld;
  logic [15:0] d3_q [3];
  dv3_side_t   d3_side;

  for (genvar l = 0; l < 3; l++) begin : g_div3
    if (l == 0) begin : g_lead
      hvn_div_pipe #(.NW(47), .DW(31), .QW(16), .SW($bits(dv3_side_t))) u_div (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(rn_vld_q),
        .num_i(rn_num_q[l]), .den_i(rn_len_q), .side_i(rn_side_q),
        .valid_o(d3_vld), .quo_o(d3_q[l]), .side_o(d3_side)
      );
    end else begin : g_lane
      hvn_div_pipe #(.NW(47), .DW(31), .QW(16), .SW($bits(dv3_side_t))) u_div (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(rn_vld_q),
        .num_i(rn_num_q[l]), .den_i(rn_len_q), .side_i(rn_side_q),
        .valid_o(), .quo_o(d3_q[l]), .side_o()
      );
    end
  end

  // sign, saturate and hold the output word
  logic [15:0] nrm_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d3_side.neg[i]) begin
        nrm_d[i] = 16'(16'd0 - d3_q[i]);
      end else begin
        nrm_d[i] = (d3_q[i] > 16'd32767) ? 16'd32767 : d3_q[i];
      end
    end
  end

  logic [15:0] out_n_q [3];
  glob_t       out_glob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        out_n_q[i] <= nrm_d[i];
      end
      out_glob_q <= d3_side.glob;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_glob_q.tex_v, out_glob_q.tex_u,
                          out_n_q[2], out_n_q[1], out_n_q[0], out_glob_q.vertex_z};

endmodule

[dv/testbench.sv]
// Testbench for heightmap_vertex_normal_unit: streams stencil words, predicts each
// result word in fixed point and checks the output stream word by word, reporting fields.
// Depends on hvn_pkg and the unit's RTL.
module testbench;
  import hvn_pkg::*;

  localparam longint One30    = 64'sd1 <<< 30;
  localparam int     MaxDim   = 4096;
  localparam int     Latency  = 179;
  localparam int     WdLimit  = 20000;

  typedef struct packed {
    logic [7:0]  h_back;
    logic [7:0]  h_left;
    logic [7:0]  h_forward;
    logic [7:0]  h_right;
    logic [7:0]  h_centre;
    logic [11:0] row;
    logic [11:0] col;
  } stencil_t;

  typedef struct packed {
    logic [24:0] tex_v;
    logic [24:0] tex_u;
    logic [15:0] normal_z;
    logic [15:0] normal_y;
    logic [15:0] normal_x;
    logic [31:0] vertex_z;
  } vertex_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  heightmap_vertex_normal_unit DUT (.*);

  always #10 clk_i = ~clk_i;

  logic [23:0] height_step_q = HeightStepRst;
  logic [23:0] u_step_q      = UStepRst;
  logic [23:0] v_step_q      = VStepRst;

  stencil_t pending_words[$];
  vertex_t  expected_vertices[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_cycles = 0;
  bit       word_taken = 1'b0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void unit_edge(input longint h, input longint hc,
                                    output longint a, output longint c);
    longint e, l, hs;
    hs = longint'(height_step_q);
    e = (h - hc) * hs / 16;
    l = longint'(isqrt(longint'(e * e) + (64'd1 << 40)));
    a = e * One30 / l;
    c = (64'sd1 <<< 50) / l;
  endfunction

  function automatic longint norm3(longint x, longint y, longint z);
    return longint'(isqrt(x * x + y * y + z * z));
  endfunction

  function automatic logic [24:0] tex_coord(logic [11:0] pos, logic [23:0] step);
    longint p, t;
    p = longint'(pos);
    if (p >= MaxDim) p = MaxDim - 1;
    t = p * longint'(step);
    return (t > 64'd16777216) ? TexOne : t[24:0];
  endfunction

  function automatic vertex_t predict_vertex(stencil_t s);
    vertex_t o;
    longint hc, ar, cr, af, cf, al, cl, ab, cb, len, half, num, q;
    longint n1[3], n2[3], sm[3];
    hc = longint'(s.h_centre);
    unit_edge(longint'(s.h_right), hc, ar, cr);
    unit_edge(longint'(s.h_forward), hc, af, cf);
    unit_edge(longint'(s.h_left), hc, al, cl);
    unit_edge(longint'(s.h_back), hc, ab, cb);
    n1[0] = -(ar * cf) / One30;
    n1[1] = -(cr * af) / One30;
    n1[2] = cr * cf / One30;
    len = norm3(n1[0], n1[1], n1[2]);
    if (len == 0) begin
      n1[0] = 0; n1[1] = 0; n1[2] = One30;
    end else begin
      for (int i = 0; i < 3; i++) n1[i] = n1[i] * One30 / len;
    end
    n2[0] = al * cb / One30;
    n2[1] = cl * ab / One30;
    n2[2] = cl * cb / One30;
    for (int i = 0; i < 3; i++) sm[i] = (n1[i] + n2[i]) / 2;
    len = norm3(sm[0], sm[1], sm[2]);
    o.vertex_z = 32'(hc * longint'(height_step_q));
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        q = (i == 2) ? 32767 : 0;
      end else begin
        half = len / 2;
        num = sm[i] * 32768;
        q = (num >= 0 ? num + half : num - half) / len;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
      end
      case (i)
        0: o.normal_x = q[15:0];
        1: o.normal_y = q[15:0];
        default: o.normal_z = q[15:0];
      endcase
    end
    o.tex_u = tex_coord(s.col, u_step_q);
    o.tex_v = tex_coord(s.row, v_step_q);
    return o;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !word_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    vertex_t got, exp_v;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_vertices.insert(expected_vertices.size(),
                               predict_vertex(stencil_t'(s_axis_tdata)));
      word_taken = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = vertex_t'(m_axis_tdata[129:0]);
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        exp_v = expected_vertices.pop_front();
        if (got !== exp_v || m_axis_tdata[135:130] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: z %h/%h n %h %h %h / %h %h %h uv %h %h / %h %h",
                     exp_v.vertex_z, got.vertex_z, exp_v.normal_x, exp_v.normal_y,
                     exp_v.normal_z, got.normal_x, got.normal_y, got.normal_z,
                     exp_v.tex_u, exp_v.tex_v, got.tex_u, got.tex_v);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_words.size() == 0 && expected_vertices.size() == 0 && !s_axis_tvalid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WdLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {8'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegHeightStep: height_step_q = val;
      RegUStep:      u_step_q = val;
      default:       v_step_q = val;
    endcase
  endtask

  task automatic set_steps(logic [23:0] hs, logic [23:0] us, logic [23:0] vs);
    write_reg(RegHeightStep, hs);
    write_reg(RegUStep, us);
    write_reg(RegVStep, vs);
  endtask

  task automatic add_word(int c, int r, int hc, int hr, int hf, int hl, int hb);
    stencil_t s;
    s.col = 12'(c); s.row = 12'(r); s.h_centre = 8'(hc); s.h_right = 8'(hr);
    s.h_forward = 8'(hf); s.h_left = 8'(hl); s.h_back = 8'(hb);
    pending_words.insert(pending_words.size(), s);
  endtask

  function automatic int near(int hc, int spread);
    int v;
    v = hc + int'($urandom_range(2 * spread)) - spread;
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  task automatic add_random(int n);
    int hc, spread;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) begin
        add_word($urandom_range(4095), $urandom_range(4095), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
      end else begin
        // smooth terrain around the centre
        hc = $urandom_range(255);
        spread = $urandom_range(12);
        add_word($urandom_range(4095), $urandom_range(4095), hc,
                 near(hc, spread), near(hc, spread), near(hc, spread), near(hc, spread));
      end
    end
  endtask

  task automatic drain;
    wait (pending_words.size() == 0 && !s_axis_tvalid && expected_vertices.size() == 0);
    @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_word(0, 0, 0, 0, 0, 0, 0);
    add_word(4095, 4095, 255, 255, 255, 255, 255);
    add_word(17, 9, 0, 255, 255, 255, 255);
    add_word(255, 255, 255, 0, 0, 0, 0);
    add_word(4095, 0, 128, 255, 0, 128, 128);
    add_word(0, 4095, 128, 128, 128, 0, 255);
    add_word(256, 256, 100, 100, 100, 100, 100);
    add_word(257, 4094, 0, 255, 0, 255, 0);
    add_word(1, 2, 255, 0, 255, 0, 255);
    add_word(2048, 1024, 10, 11, 9, 12, 8);
    add_word(3000, 3001, 200, 255, 255, 0, 0);
    add_word(4095, 4095, 0, 0, 0, 255, 255);
    drain();
    set_steps(24'hFFFFFF, 24'hFFFFFF, 24'h000000);
    add_word(4095, 4095, 255, 255, 255, 255, 255);
    add_word(4095, 4095, 255, 0, 0, 0, 0);
    add_word(1, 4095, 0, 255, 255, 255, 255);
    add_word(0, 0, 1, 0, 2, 0, 2);
    drain();
    set_steps(24'h000000, 24'h000001, 24'h001001);
    add_word(4095, 4095, 255, 0, 255, 0, 255);
    add_word(4095, 4095, 0, 255, 0, 255, 0);
    drain();

    set_steps(HeightStepRst, UStepRst, VStepRst);
    send_idle_pct = 76;
    add_random(120);
    drain();

    set_steps(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
              24'($urandom_range(24'hFFFFFF)));
    send_idle_pct = 0;
    recv_stall_pct = 76;
    add_random(120);
    drain();

    set_steps(24'($urandom_range(65535)), 24'($urandom_range(8191)),
              24'($urandom_range(8191)));
    send_idle_pct = 27;
    recv_stall_pct = 27;
    add_random(120);
    drain();

    set_steps(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(8191)),
              24'($urandom_range(8191)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 600;
    add_random(120);
    drain();

    repeat (Latency + 20) @(posedge clk_i);
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
